@@ design/priority_sorted_task_list_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Priority sorted task list assertion macros
// Shorthand for the clocked implication checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SORTED_TASK_LIST_UNIT_ASSERT_SVH
`define PRIORITY_SORTED_TASK_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pstl_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority sorted task list package
// Table sizes, node and value types, mode and status codes, beat structs.
// ----------------------------------------------------------------------------
package pstl_pkg;

  localparam int MAX_TASKS  = 16;
  localparam int TASK_DEPTH = MAX_TASKS + 2;
  localparam int NODE_W     = 5;
  localparam int PRIO_W     = 16;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [PRIO_W-1:0] prio_t;

  localparam node_t DEPTH_NODE = node_t'(TASK_DEPTH);
  localparam node_t HEAD_NODE  = node_t'(0);
  localparam node_t TAIL_NODE  = node_t'(1);
  localparam node_t FIRST_FREE = node_t'(2);

  localparam prio_t TOP_VALUE   = 16'hFFFF;
  localparam prio_t CLAMP_VALUE = 16'hFFFE;
  localparam prio_t MID_VALUE   = 16'h8000;
  localparam prio_t LOW_VALUE   = 16'h0000;

  localparam logic [1:0] MODE_MAKE = 2'd0;
  localparam logic [1:0] MODE_KILL = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  localparam logic [1:0] ST_CREATED = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_SERVED  = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    prio_t      priority_req;
    node_t      handle;
  } task_in_t;

  typedef struct packed {
    node_t      task_handle;
    logic [1:0] status;
    logic       last;
  } task_out_t;

  typedef struct packed {
    node_t nlink_raddr;
    logic  nlink_we;
    node_t nlink_waddr;
    node_t nlink_wdata;
    node_t plink_raddr;
    logic  plink_we;
    node_t plink_waddr;
    node_t plink_wdata;
  } link_ctrl_t;

  function automatic node_t step_pos(input node_t p);
    node_t q;
    q = p + 1'b1;
    return (q >= DEPTH_NODE) ? '0 : q;
  endfunction

endpackage

@@ design/priority_sorted_task_list_unit.sv @@
// ----------------------------------------------------------------------------
// Priority sorted task list unit
// Task table kept as a doubly linked list in ascending priority, with free
// handles recycled through a ring. Commands make, request kill and run.
//
//   Channel  Ports                     Handshake
//   input    start, busy, in_data      beat taken when start and not busy
//   result   out_valid, out_data       one-cycle strobe, never stalled
//
// Make walks past the entries of lower priority, then writes the new links in
// S_MK_LINK1 and S_MK_LINK2; on a full table it reports from dispatch. Request
// kill and the unused mode end in dispatch; run walks the live entries and
// then unlinks killed ones. One link is followed per cycle through the link
// table. Reset is synchronous and restores the whole table at once.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module priority_sorted_task_list_unit
  import pstl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  task_in_t  in_data,
  output logic      out_valid,
  output task_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MK_WALK,
    S_MK_LINK1,
    S_MK_LINK2,
    S_RUN_WALK,
    S_RUN_KILL
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  prio_t      prio_r, prio_nxt;
  node_t      handle_r, handle_nxt;
  node_t      node_r, node_nxt;
  node_t      prv_r, prv_nxt;
  node_t      cur_r, cur_nxt;
  node_t      pend_r, pend_nxt;
  logic       pend_v_r, pend_v_nxt;
  node_t      take_r, take_nxt;
  node_t      ret_r, ret_nxt;
  logic       out_valid_r, out_valid_nxt;
  task_out_t  out_data_r, out_data_nxt;

  prio_t      order_r [TASK_DEPTH];
  logic       kill_r [TASK_DEPTH];
  node_t      ring_r [TASK_DEPTH];

  logic       ord_we;
  node_t      ord_waddr;
  prio_t      ord_wdata;
  logic       kill_we;
  node_t      kill_waddr;
  logic       kill_wdata;
  logic       ring_we;
  node_t      ring_waddr;
  node_t      ring_wdata;

  prio_t      ord_rd;
  logic       kill_rd;
  node_t      ring_rd;
  logic       cur_end;

  link_ctrl_t link_ctrl;
  node_t      nlink_rdata;
  node_t      plink_rdata;

  pstl_link_table u_links (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (link_ctrl),
    .nlink_rdata (nlink_rdata),
    .plink_rdata (plink_rdata)
  );

  always_comb begin
    ord_rd  = '0;
    kill_rd = 1'b0;
    ring_rd = '0;
    if (cur_r < DEPTH_NODE) begin
      ord_rd  = order_r[cur_r];
      kill_rd = kill_r[cur_r];
    end
    if (take_r < DEPTH_NODE) begin
      ring_rd = ring_r[take_r];
    end
  end

  assign cur_end = (cur_r >= DEPTH_NODE) || (cur_r == TAIL_NODE) || (cur_r == HEAD_NODE);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    prio_nxt      = prio_r;
    handle_nxt    = handle_r;
    node_nxt      = node_r;
    prv_nxt       = prv_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    take_nxt      = take_r;
    ret_nxt       = ret_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    ord_we     = 1'b0;
    ord_waddr  = node_r;
    ord_wdata  = prio_r;
    kill_we    = 1'b0;
    kill_waddr = node_r;
    kill_wdata = 1'b0;
    ring_we    = 1'b0;
    ring_waddr = ret_r;
    ring_wdata = cur_r;

    link_ctrl             = '0;
    link_ctrl.nlink_raddr = cur_r;
    link_ctrl.plink_raddr = cur_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt   = in_data.mode;
          prio_nxt   = (in_data.priority_req == TOP_VALUE) ? CLAMP_VALUE
                                                           : in_data.priority_req;
          handle_nxt = in_data.handle;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (mode_r)
          MODE_MAKE: begin
            if (take_r == ret_r || take_r >= DEPTH_NODE || ring_rd >= DEPTH_NODE) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.task_handle = '0;
              out_data_nxt.status      = ST_FULL;
              out_data_nxt.last        = 1'b1;
              state_nxt                = S_IDLE;
            end else begin
              node_nxt              = ring_rd;
              take_nxt              = step_pos(take_r);
              ord_we                = 1'b1;
              ord_waddr             = ring_rd;
              kill_we               = 1'b1;
              kill_waddr            = ring_rd;
              kill_wdata            = 1'b0;
              prv_nxt               = HEAD_NODE;
              link_ctrl.nlink_raddr = HEAD_NODE;
              cur_nxt               = nlink_rdata;
              state_nxt             = S_MK_WALK;
            end
          end
          MODE_KILL: begin
            if (handle_r >= FIRST_FREE && handle_r < DEPTH_NODE) begin
              kill_we    = 1'b1;
              kill_waddr = handle_r;
              kill_wdata = 1'b1;
            end
            state_nxt = S_IDLE;
          end
          MODE_RUN: begin
            link_ctrl.nlink_raddr = HEAD_NODE;
            cur_nxt               = nlink_rdata;
            pend_v_nxt            = 1'b0;
            state_nxt             = S_RUN_WALK;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MK_WALK: begin
        if (cur_r >= DEPTH_NODE || cur_r == TAIL_NODE || ord_rd >= prio_r) begin
          if (cur_r >= DEPTH_NODE) begin
            cur_nxt = TAIL_NODE;
          end
          state_nxt = S_MK_LINK1;
        end else begin
          prv_nxt = cur_r;
          cur_nxt = nlink_rdata;
        end
      end
      S_MK_LINK1: begin
        link_ctrl.nlink_we    = 1'b1;
        link_ctrl.nlink_waddr = node_r;
        link_ctrl.nlink_wdata = cur_r;
        link_ctrl.plink_we    = 1'b1;
        link_ctrl.plink_waddr = node_r;
        link_ctrl.plink_wdata = prv_r;
        state_nxt             = S_MK_LINK2;
      end
      S_MK_LINK2: begin
        link_ctrl.nlink_we       = 1'b1;
        link_ctrl.nlink_waddr    = prv_r;
        link_ctrl.nlink_wdata    = node_r;
        link_ctrl.plink_we       = 1'b1;
        link_ctrl.plink_waddr    = cur_r;
        link_ctrl.plink_wdata    = node_r;
        out_valid_nxt            = 1'b1;
        out_data_nxt.task_handle = node_r;
        out_data_nxt.status      = ST_CREATED;
        out_data_nxt.last        = 1'b1;
        state_nxt                = S_IDLE;
      end
      S_RUN_WALK: begin
        if (cur_end) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.task_handle = pend_v_r ? pend_r : '0;
          out_data_nxt.status      = pend_v_r ? ST_SERVED : ST_NONE;
          out_data_nxt.last        = 1'b1;
          link_ctrl.nlink_raddr    = HEAD_NODE;
          cur_nxt                  = nlink_rdata;
          state_nxt                = S_RUN_KILL;
        end else begin
          if (!kill_rd) begin
            if (pend_v_r) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.task_handle = pend_r;
              out_data_nxt.status      = ST_SERVED;
              out_data_nxt.last        = 1'b0;
            end
            pend_nxt   = cur_r;
            pend_v_nxt = 1'b1;
          end
          cur_nxt = nlink_rdata;
        end
      end
      S_RUN_KILL: begin
        if (cur_end) begin
          state_nxt = S_IDLE;
        end else begin
          if (kill_rd) begin
            link_ctrl.nlink_we    = (plink_rdata < DEPTH_NODE);
            link_ctrl.nlink_waddr = plink_rdata;
            link_ctrl.nlink_wdata = nlink_rdata;
            link_ctrl.plink_we    = (nlink_rdata < DEPTH_NODE);
            link_ctrl.plink_waddr = nlink_rdata;
            link_ctrl.plink_wdata = plink_rdata;
            ring_we               = (ret_r < DEPTH_NODE);
            ret_nxt               = step_pos(ret_r);
          end
          cur_nxt = nlink_rdata;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      take_r      <= FIRST_FREE;
      ret_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      take_r      <= take_nxt;
      ret_r       <= ret_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    prio_r     <= prio_nxt;
    handle_r   <= handle_nxt;
    node_r     <= node_nxt;
    prv_r      <= prv_nxt;
    cur_r      <= cur_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_DEPTH; i++) begin
        order_r[i] <= (i == int'(HEAD_NODE)) ? LOW_VALUE :
                      (i == int'(TAIL_NODE)) ? TOP_VALUE : MID_VALUE;
        kill_r[i]  <= 1'b0;
        ring_r[i]  <= node_t'(i);
      end
    end else begin
      if (ord_we) begin
        order_r[ord_waddr] <= ord_wdata;
      end
      if (kill_we) begin
        kill_r[kill_waddr] <= kill_wdata;
      end
      if (ring_we) begin
        ring_r[ring_waddr] <= ring_wdata;
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/pstl_link_table.sv @@
// ----------------------------------------------------------------------------
// Priority sorted task list link table
// Forward and backward links of every node, one read and one write each.
// ----------------------------------------------------------------------------
module pstl_link_table
  import pstl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  link_ctrl_t ctrl,
  output node_t      nlink_rdata,
  output node_t      plink_rdata
);

  node_t nlink_r [TASK_DEPTH];
  node_t plink_r [TASK_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_DEPTH; i++) begin
        nlink_r[i] <= (i == int'(HEAD_NODE)) ? TAIL_NODE : '0;
        plink_r[i] <= (i == int'(TAIL_NODE)) ? HEAD_NODE : '0;
      end
    end else begin
      if (ctrl.nlink_we) begin
        nlink_r[ctrl.nlink_waddr] <= ctrl.nlink_wdata;
      end
      if (ctrl.plink_we) begin
        plink_r[ctrl.plink_waddr] <= ctrl.plink_wdata;
      end
    end
  end

  always_comb begin
    nlink_rdata = '0;
    plink_rdata = '0;
    if (ctrl.nlink_raddr < DEPTH_NODE) begin
      nlink_rdata = nlink_r[ctrl.nlink_raddr];
    end
    if (ctrl.plink_raddr < DEPTH_NODE) begin
      plink_rdata = plink_r[ctrl.plink_raddr];
    end
  end

endmodule

@@ design/pstl_checker.sv @@
// ----------------------------------------------------------------------------
// Priority sorted task list checker
// Port-level checks on command and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_sorted_task_list_unit_assert.svh"

module pstl_checker
  import pstl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input task_in_t  in_data,
  input logic      out_valid,
  input task_out_t out_data
);

  logic in_beat;
  logic make_res;
  logic more_res;

  assign in_beat  = start && !busy;
  assign make_res = out_valid && (out_data.status == ST_CREATED || out_data.status == ST_FULL);
  assign more_res = out_valid && !out_data.last;

  `PSTL_ASSERT_NXT(a_beat_sets_busy, clk, rst_n, in_beat, busy, "busy missing after beat")

  `PSTL_ASSERT_NXT(a_busy_needs_beat, clk, rst_n, !start && !busy, !busy, "busy without beat")

  `PSTL_ASSERT_IMP(a_result_in_work, clk, rst_n, out_valid, $past(busy), "result outside work")

  `PSTL_ASSERT_IMP(a_make_ends_work, clk, rst_n, make_res, !busy && out_data.last, "make not final")

  `PSTL_ASSERT_NXT(a_more_follows, clk, rst_n, more_res, busy, "run ended before last result")

endmodule

bind priority_sorted_task_list_unit pstl_checker u_pstl_checker (.*);

@@ bench/priority_sorted_task_list_unit_test.sv @@
// ----------------------------------------------------------------------------
// Priority sorted task list unit testbench
// Drives make, request kill and run commands through the start/busy port and
// checks every result beat against a cycle-free model of the sorted task
// table and its free ring. Directed commands cover the priority extremes, the
// clamp, equal priorities, ignored handles, unused modes, an empty run and
// kills of free nodes. Random bursts then fill the table past full and drain
// it again.
// ----------------------------------------------------------------------------
module priority_sorted_task_list_unit_test;
  import pstl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 160;
  localparam int REPORT_LIMIT   = 10;

  class task_list_scoreboard;
    node_t     fwd_link[TASK_DEPTH];
    node_t     back_link[TASK_DEPTH];
    prio_t     rank[TASK_DEPTH];
    bit        marked[TASK_DEPTH];
    node_t     ring[TASK_DEPTH];
    int        take_idx;
    int        give_idx;
    task_out_t pending_results[$];
    int        failures;
    int        results_checked;
    int        makes;
    int        kills;
    int        runs;
    int        fulls;
    int        empty_runs;

    function new();
      for (int i = 0; i < TASK_DEPTH; i++) begin
        fwd_link[i]  = HEAD_NODE;
        back_link[i] = HEAD_NODE;
        rank[i]      = MID_VALUE;
        marked[i]    = 1'b0;
        ring[i]      = node_t'(i);
      end
      fwd_link[HEAD_NODE]  = TAIL_NODE;
      back_link[TAIL_NODE] = HEAD_NODE;
      rank[HEAD_NODE]      = LOW_VALUE;
      rank[TAIL_NODE]      = TOP_VALUE;
      take_idx = FIRST_FREE;
      give_idx = 0;
    endfunction

    function void push_result(node_t h, logic [1:0] st, logic fin);
      task_out_t r;
      r.task_handle = h;
      r.status      = st;
      r.last        = fin;
      pending_results.push_back(r);
    endfunction

    function int ring_next(int p);
      return (p + 1 >= TASK_DEPTH) ? 0 : p + 1;
    endfunction

    function void predict_make(prio_t prio);
      node_t n;
      node_t prv;
      node_t nxt;
      prio_t p;
      makes++;
      if (take_idx == give_idx || take_idx >= TASK_DEPTH || ring[take_idx] >= DEPTH_NODE) begin
        fulls++;
        push_result(HEAD_NODE, ST_FULL, 1'b1);
        return;
      end
      n = ring[take_idx];
      take_idx = ring_next(take_idx);
      p = (prio == TOP_VALUE) ? CLAMP_VALUE : prio;
      rank[n]   = p;
      marked[n] = 1'b0;
      prv = HEAD_NODE;
      nxt = fwd_link[HEAD_NODE];
      for (int s = 0; s < TASK_DEPTH; s++) begin
        if (nxt >= DEPTH_NODE || nxt == TAIL_NODE || rank[nxt] >= p) break;
        prv = nxt;
        nxt = fwd_link[nxt];
      end
      if (nxt >= DEPTH_NODE) nxt = TAIL_NODE;
      back_link[n]   = prv;
      fwd_link[n]    = nxt;
      fwd_link[prv]  = n;
      back_link[nxt] = n;
      push_result(n, ST_CREATED, 1'b1);
    endfunction

    function void predict_run();
      node_t served[$];
      node_t cur;
      node_t nxt;
      node_t prv;
      runs++;
      cur = fwd_link[HEAD_NODE];
      for (int s = 0; s < TASK_DEPTH; s++) begin
        if (cur >= DEPTH_NODE || cur == TAIL_NODE || cur == HEAD_NODE) break;
        if (!marked[cur] && served.size() < MAX_TASKS) served.push_back(cur);
        cur = fwd_link[cur];
      end
      cur = fwd_link[HEAD_NODE];
      for (int s = 0; s < TASK_DEPTH; s++) begin
        if (cur >= DEPTH_NODE || cur == TAIL_NODE || cur == HEAD_NODE) break;
        nxt = fwd_link[cur];
        if (marked[cur]) begin
          prv = back_link[cur];
          if (prv < DEPTH_NODE) fwd_link[prv] = nxt;
          if (nxt < DEPTH_NODE) back_link[nxt] = prv;
          if (give_idx < TASK_DEPTH) ring[give_idx] = cur;
          give_idx = ring_next(give_idx);
        end
        cur = nxt;
      end
      if (served.size() == 0) begin
        empty_runs++;
        push_result(HEAD_NODE, ST_NONE, 1'b1);
      end else begin
        foreach (served[i]) push_result(served[i], ST_SERVED, i == served.size() - 1);
      end
    endfunction

    function void note_command(task_in_t c);
      case (c.mode)
        MODE_MAKE: predict_make(c.priority_req);
        MODE_KILL: begin
          kills++;
          if (c.handle >= FIRST_FREE && c.handle < DEPTH_NODE) marked[c.handle] = 1'b1;
        end
        MODE_RUN: predict_run();
        default: ;
      endcase
    endfunction

    function void report(string what, task_out_t want, task_out_t got);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("mismatch %0s: expected handle %0d status %0d last %0b, got handle %0d status %0d last %0b",
                 what, want.task_handle, want.status, want.last,
                 got.task_handle, got.status, got.last);
    endfunction

    function void check_result(task_out_t got);
      task_out_t want;
      if (pending_results.size() == 0) begin
        report("unexpected beat", '0, got);
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.task_handle !== want.task_handle || got.status !== want.status ||
          got.last !== want.last)
        report("result", want, got);
    endfunction

    function void close_out();
      if (pending_results.size() != 0) begin
        failures++;
        $display("%0d expected results never arrived", pending_results.size());
      end
    endfunction

    function node_t pick_live();
      node_t live[$];
      node_t cur;
      cur = fwd_link[HEAD_NODE];
      for (int s = 0; s < TASK_DEPTH; s++) begin
        if (cur >= DEPTH_NODE || cur == TAIL_NODE || cur == HEAD_NODE) break;
        live.push_back(cur);
        cur = fwd_link[cur];
      end
      if (live.size() == 0) return node_t'($urandom_range(FIRST_FREE, TASK_DEPTH - 1));
      return live[$urandom_range(0, live.size() - 1)];
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  task_in_t  in_data;
  logic      out_valid;
  task_out_t out_data;

  task_list_scoreboard sb = new();
  bit quiet_stretch;
  int idle_cycles;

  priority_sorted_task_list_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) sb.check_result(out_data);
      if (start && busy === 1'b0) sb.note_command(in_data);
      if (out_valid === 1'b1 || (start && busy === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
          $display("FAIL priority_sorted_task_list_unit");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(input logic [1:0] mode, input prio_t prio, input node_t h);
    task_in_t beat;
    beat.mode         = mode;
    beat.priority_req = prio;
    beat.handle       = h;
    in_data <= beat;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (!quiet_stretch && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic prio_t random_prio();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick < 2) begin
      case ($urandom_range(0, 4))
        0: return LOW_VALUE;
        1: return prio_t'(1);
        2: return MID_VALUE;
        3: return CLAMP_VALUE;
        default: return TOP_VALUE;
      endcase
    end
    if (pick < 4) return prio_t'($urandom_range(100, 103));
    return prio_t'($urandom_range(0, 65535));
  endfunction

  function automatic node_t any_node();
    return node_t'($urandom_range(0, 31));
  endfunction

  initial begin
    int counted;
    int step_no;
    int burst;
    node_t h;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    quiet_stretch = 1'b0;
    idle_cycles   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(MODE_RUN, prio_t'(16'h5A5A), any_node());
    send_beat(MODE_MAKE, LOW_VALUE, any_node());
    send_beat(MODE_MAKE, TOP_VALUE, any_node());
    send_beat(MODE_MAKE, CLAMP_VALUE, any_node());
    send_beat(MODE_MAKE, MID_VALUE, any_node());
    send_beat(MODE_MAKE, prio_t'(1), any_node());
    send_beat(MODE_MAKE, LOW_VALUE, any_node());
    send_beat(MODE_MAKE, TOP_VALUE, any_node());
    send_beat(MODE_RUN, '0, any_node());
    send_beat(MODE_KILL, random_prio(), HEAD_NODE);
    send_beat(MODE_KILL, random_prio(), TAIL_NODE);
    send_beat(MODE_KILL, random_prio(), DEPTH_NODE);
    send_beat(MODE_KILL, random_prio(), node_t'(31));
    send_beat(MODE_KILL, random_prio(), node_t'(3));
    send_beat(MODE_KILL, random_prio(), node_t'(TASK_DEPTH - 1));
    send_beat(2'd3, prio_t'(16'hFFFF), node_t'(31));
    send_beat(MODE_RUN, '0, any_node());
    send_beat(MODE_KILL, random_prio(), sb.pick_live());
    send_beat(MODE_KILL, random_prio(), sb.pick_live());
    send_beat(MODE_RUN, '0, any_node());

    counted = 0;
    step_no = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet_stretch = (step_no >= 12 && step_no < 26);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          burst = $urandom_range(1, 12);
          repeat (burst) begin
            send_beat(MODE_MAKE, random_prio(), any_node());
            counted++;
          end
        end
        9, 10, 11, 12, 13: begin
          burst = $urandom_range(1, 5);
          repeat (burst) begin
            case ($urandom_range(0, 9))
              0, 1: h = node_t'($urandom_range(FIRST_FREE, TASK_DEPTH - 1));
              2:    h = any_node();
              default: h = sb.pick_live();
            endcase
            send_beat(MODE_KILL, random_prio(), h);
            counted++;
          end
        end
        14, 15, 16, 17: begin
          send_beat(MODE_RUN, random_prio(), any_node());
          counted++;
        end
        default: begin
          send_beat(2'd3, random_prio(), any_node());
          counted++;
        end
      endcase
      step_no++;
    end
    quiet_stretch = 1'b0;
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();

    $display("covered %0d makes (%0d on a full table), %0d kill requests, %0d runs (%0d empty)",
             sb.makes, sb.fulls, sb.kills, sb.runs, sb.empty_runs);
    $display("checked %0d result beats, %0d failures", sb.results_checked, sb.failures);
    if (sb.failures == 0) begin
      $display("PASS priority_sorted_task_list_unit");
    end else begin
      $display("FAIL priority_sorted_task_list_unit");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/pstl_pkg.sv
design/pstl_link_table.sv
design/priority_sorted_task_list_unit.sv
design/pstl_checker.sv
bench/priority_sorted_task_list_unit_test.sv
